// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files of the bandit arm selector.
// Needs nothing else; files that check their logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ucbsel_pkg.sv =====
// Package of the bandit arm selector: widths, reset values, codes and the
// divider request and response types. Depends on nothing.
package ucbsel_pkg;

    localparam int NUM_ARMS_DEF = 8;

    localparam int MEAN_W  = 17;
    localparam int COUNT_W = 32;
    localparam int DIV_N_W = 36;
    localparam int DIV_D_W = 32;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;
    localparam int CFG_W     = 16;

    localparam logic [15:0] EXPLORE_RESET  = 16'd4096;
    localparam logic [3:0]  ENABLED_RESET  = 4'd8;
    localparam logic [15:0] WALK_CAP_RESET = 16'd2000;
    localparam logic [7:0]  STEP_CAP_RESET = 8'd7;
    localparam logic [15:0] WALK_RESET     = 16'd100;
    localparam logic [7:0]  STEP_RESET     = 8'd1;

    localparam logic [MEAN_W-1:0]  REWARD_ONE = 17'h10000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0]        LN2_Q16    = 16'd45426;

    localparam logic REQ_SELECT = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        CFG_EXPLORE,
        CFG_ENABLED,
        CFG_WALK_CAP,
        CFG_STEP_CAP
    } cfg_idx_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
        logic [DIV_D_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== design/ucbsel_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ucbsel_pkg for the request and response types.
`include "assert_macros.svh"

module ucbsel_div import ucbsel_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [DIV_N_W-1:0] q_reg;
    logic [DIV_D_W-1:0] r_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [DIV_D_W:0]   r_shift;
    logic               ge;
    logic [DIV_D_W:0]   r_next;

    assign r_shift = {r_reg, q_reg[DIV_N_W-1]};
    assign ge      = (r_shift >= {1'b0, d_reg});
    assign r_next  = ge ? (r_shift - {1'b0, d_reg}) : r_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_N_W);
                q_reg    <= req.dividend;
                r_reg    <= '0;
                d_reg    <= req.divisor;
            end else if (busy_reg) begin
                q_reg   <= {q_reg[DIV_N_W-2:0], ge};
                r_reg   <= r_next[DIV_D_W-1:0];
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

    `ASSERT_CLKD(a_div_no_restart, aclk, aresetn, req.start |-> !busy_reg, "divider restarted while busy")

endmodule

// ===== design/ucbsel_arm_mem.sv =====
// Per-arm state memory: running mean and pull count, read data registered and valid the cycle after rd_en.
// Valid bits make entries read as zero until first written. Uses ucbsel_pkg.
`include "assert_macros.svh"

module ucbsel_arm_mem import ucbsel_pkg::*; #(
    parameter int NUM_ARMS = NUM_ARMS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [$clog2(NUM_ARMS)-1:0] rd_addr,
    output logic [MEAN_W-1:0]           rd_mean,
    output logic [COUNT_W-1:0]          rd_count,
    input  logic                        wr_en,
    input  logic [$clog2(NUM_ARMS)-1:0] wr_addr,
    input  logic [MEAN_W-1:0]           wr_mean,
    input  logic [COUNT_W-1:0]          wr_count
);

    localparam int ENTRY_W = MEAN_W + COUNT_W;

    logic [ENTRY_W-1:0]  arm_mem [NUM_ARMS];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                rd_valid_reg;
    logic [NUM_ARMS-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            arm_mem[wr_addr] <= {wr_mean, wr_count};
        end
        if (rd_en) begin
            rd_data_reg <= arm_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_mean  = rd_valid_reg ? rd_data_reg[ENTRY_W-1:COUNT_W] : '0;
    assign rd_count = rd_valid_reg ? rd_data_reg[COUNT_W-1:0] : '0;

    `ASSERT_CLKD(a_mem_no_collide, aclk, aresetn, (rd_en && wr_en) |-> (rd_addr != wr_addr), "read and write hit the same arm")

endmodule

// ===== design/ucb_bandit_arm_selector_unit.sv =====
// Top level of the UCB1 bandit arm selector: handshakes, control sequencer,
// log and square-root iterations. Uses ucbsel_pkg, ucbsel_div, ucbsel_arm_mem.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata, s_tuser (request kind)
//  m_      | out       | m_tvalid/m_tready  | m_tdata, m_tuser (budget flag)
//  cfg_    | in        | cfg_we             | cfg_addr, cfg_wdata
//
// An update uses the serial divider for the reward (skipped when the bound is zero), then for the mean step.
// A select with untried arms scans the enabled arms, takes a modulo on the divider and walks the mask.
// A UCB select runs the untried scan and the log iterations, then per arm a divider pass and
// square-root iterations, and a final modulo on the divider.
// Reset is synchronous and active low; the arm memory reads as zero until written.
// One transaction is worked on at a time; a stalled result holds the sequencer.
`include "assert_macros.svh"

module ucb_bandit_arm_selector_unit import ucbsel_pkg::*; #(
    parameter int NUM_ARMS = NUM_ARMS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // arm_index[2:0], heuristic[22:3], heuristic_bound[42:23], random_word[74:43]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // chosen_arm[2:0], walk_count[18:3], step_limit[26:19]
    output logic [M_TDATA_W-1:0] m_tdata,
    // budget_valid[0]
    output logic [0:0]           m_tuser,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(NUM_ARMS);
    localparam int UW = $clog2(NUM_ARMS + 1);
    localparam logic [37:0] SQ_BIT0 = 38'h1 << 36;

    typedef enum logic [4:0] {
        ST_IDLE, ST_U_RD, ST_U_CAP, ST_U_REW, ST_U_DELTA, ST_U_DWAIT,
        ST_S_RD, ST_S_CHK, ST_LOG_NORM, ST_LOG_SQ, ST_LN,
        ST_A_RD, ST_A_CAP, ST_A_DIV, ST_SQRT, ST_TERM, ST_SCORE,
        ST_MOD, ST_MOD_WAIT, ST_PICK, ST_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] explore_reg;
    logic [3:0]  enabled_reg;
    logic [15:0] walk_cap_reg;
    logic [7:0]  step_cap_reg;

    logic [COUNT_W-1:0] total_count_reg;
    logic [15:0]        walk_reg;
    logic [7:0]         step_reg;

    logic [2:0]  arm_in_reg;
    logic [19:0] h_reg;
    logic [19:0] bound_reg;
    logic [31:0] rnd_reg;

    logic [MEAN_W-1:0]  mean_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [MEAN_W-1:0]  reward_reg;
    logic               neg_reg;

    logic [UW-1:0]       arm_reg;
    logic [NUM_ARMS-1:0] mask_reg;
    logic [UW-1:0]       n_reg;
    logic [UW-1:0]       k_reg;
    logic                ucb_reg;
    logic                single_reg;
    logic [AW-1:0]       chosen_reg;

    logic [31:0] m_reg;
    logic [4:0]  lk_reg;
    logic [15:0] frac_reg;
    logic [4:0]  it_reg;
    logic [20:0] ln_reg;
    logic [37:0] sq_v_reg;
    logic [37:0] sq_res_reg;
    logic [37:0] sq_bit_reg;
    logic [22:0] term_reg;
    logic [23:0] best_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               mem_re;
    logic [AW-1:0]      mem_rd_addr;
    logic [MEAN_W-1:0]  mem_rd_mean;
    logic [COUNT_W-1:0] mem_rd_count;
    logic               mem_we;
    logic [MEAN_W-1:0]  mem_wr_mean;

    logic [UW-1:0]      used_w;
    logic               arm_fits;
    logic [AW-1:0]      arm_idx;
    logic               last_arm;
    logic [19:0]        hc;
    logic [17:0]        diff;
    logic [16:0]        mag;
    logic [COUNT_W-1:0] count_sat;
    logic               untried;
    logic [UW-1:0]      n_new;
    logic [63:0]        sq_prod;
    logic [32:0]        sq_t;
    logic [36:0]        ln_prod;
    logic [37:0]        sq_sum;
    logic [34:0]        term_prod;
    logic [23:0]        score;
    logic [16:0]        walk_dbl;
    logic [15:0]        walk_next;
    logic [8:0]         step_inc;
    logic [7:0]         step_next;
    logic               out_load;

    assign used_w    = (32'(enabled_reg) > NUM_ARMS) ? UW'(NUM_ARMS) : UW'(enabled_reg);
    assign arm_fits  = (32'(s_tdata[2:0]) < 32'(used_w));
    assign arm_idx   = arm_reg[AW-1:0];
    assign last_arm  = (arm_reg == used_w - UW'(1));
    assign hc        = (h_reg > bound_reg) ? bound_reg : h_reg;
    assign diff      = {1'b0, reward_reg} - {1'b0, mean_reg};
    assign mag       = diff[17] ? 17'(-diff) : diff[16:0];
    assign count_sat = (count_reg == COUNT_MAX) ? count_reg : count_reg + 32'd1;
    assign untried   = (mem_rd_count == '0);
    assign n_new     = n_reg + UW'(untried);
    assign sq_prod   = 64'(m_reg) * 64'(m_reg);
    assign sq_t      = sq_prod[63:31];
    assign ln_prod   = 37'({lk_reg, frac_reg}) * 37'(LN2_Q16);
    assign sq_sum    = sq_res_reg + sq_bit_reg;
    assign term_prod = 35'(explore_reg) * 35'(sq_res_reg[18:0]);
    assign score     = 24'(mean_reg) + 24'(term_reg);
    assign walk_dbl  = {walk_reg, 1'b0};
    assign walk_next = (walk_dbl < {1'b0, walk_cap_reg}) ? walk_dbl[15:0] : walk_cap_reg;
    assign step_inc  = {1'b0, step_reg} + 9'd1;
    assign step_next = (step_inc < {1'b0, step_cap_reg}) ? step_inc[7:0] : step_cap_reg;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign mem_re      = (state_reg == ST_U_RD) || (state_reg == ST_S_RD)
                         || (state_reg == ST_A_RD);
    assign mem_rd_addr = (state_reg == ST_U_RD) ? AW'(arm_in_reg) : arm_idx;
    assign mem_we      = (state_reg == ST_U_DWAIT) && div_rsp.done;
    assign mem_wr_mean = neg_reg ? (mean_reg - div_rsp.quot[16:0])
                                 : (mean_reg + div_rsp.quot[16:0]);

    always_comb begin
        div_req = '0;
        unique case (state_reg)
            ST_U_CAP: begin
                div_req.start    = (bound_reg != '0);
                div_req.dividend = {bound_reg - hc, 16'b0};
                div_req.divisor  = 32'(bound_reg);
            end
            ST_U_DELTA: begin
                div_req.start    = 1'b1;
                div_req.dividend = 36'(mag);
                div_req.divisor  = count_sat;
            end
            ST_A_CAP: begin
                div_req.start    = 1'b1;
                div_req.dividend = 36'({ln_reg, 1'b0});
                div_req.divisor  = mem_rd_count;
            end
            ST_MOD: begin
                div_req.start    = 1'b1;
                div_req.dividend = 36'(rnd_reg);
                div_req.divisor  = 32'(n_reg);
            end
            default: begin
            end
        endcase
    end

    ucbsel_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    ucbsel_arm_mem #(
        .NUM_ARMS (NUM_ARMS)
    ) u_arm_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (mem_re),
        .rd_addr  (mem_rd_addr),
        .rd_mean  (mem_rd_mean),
        .rd_count (mem_rd_count),
        .wr_en    (mem_we),
        .wr_addr  (AW'(arm_in_reg)),
        .wr_mean  (mem_wr_mean),
        .wr_count (count_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            explore_reg     <= EXPLORE_RESET;
            enabled_reg     <= ENABLED_RESET;
            walk_cap_reg    <= WALK_CAP_RESET;
            step_cap_reg    <= STEP_CAP_RESET;
            total_count_reg <= '0;
            walk_reg        <= WALK_RESET;
            step_reg        <= STEP_RESET;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_EXPLORE:  explore_reg  <= cfg_wdata;
                    CFG_ENABLED:  enabled_reg  <= cfg_wdata[3:0];
                    CFG_WALK_CAP: walk_cap_reg <= cfg_wdata;
                    CFG_STEP_CAP: step_cap_reg <= cfg_wdata[7:0];
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        arm_in_reg <= s_tdata[2:0];
                        h_reg      <= s_tdata[22:3];
                        bound_reg  <= s_tdata[42:23];
                        rnd_reg    <= s_tdata[74:43];
                        if (s_tuser[0] == REQ_UPDATE) begin
                            if (arm_fits) begin
                                state_reg <= ST_U_RD;
                            end
                        end else if (used_w <= UW'(1)) begin
                            single_reg <= 1'b1;
                            state_reg  <= ST_OUT;
                        end else begin
                            single_reg <= 1'b0;
                            arm_reg    <= '0;
                            mask_reg   <= '0;
                            n_reg      <= '0;
                            state_reg  <= ST_S_RD;
                        end
                    end
                end
                ST_U_RD: begin
                    state_reg <= ST_U_CAP;
                end
                ST_U_CAP: begin
                    mean_reg  <= mem_rd_mean;
                    count_reg <= mem_rd_count;
                    state_reg <= ST_U_REW;
                end
                ST_U_REW: begin
                    if (bound_reg == '0) begin
                        reward_reg <= REWARD_ONE;
                        state_reg  <= ST_U_DELTA;
                    end else if (div_rsp.done) begin
                        reward_reg <= div_rsp.quot[16:0];
                        state_reg  <= ST_U_DELTA;
                    end
                end
                ST_U_DELTA: begin
                    count_reg <= count_sat;
                    neg_reg   <= diff[17];
                    state_reg <= ST_U_DWAIT;
                end
                ST_U_DWAIT: begin
                    if (div_rsp.done) begin
                        if (total_count_reg != COUNT_MAX) begin
                            total_count_reg <= total_count_reg + 32'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_S_RD: begin
                    state_reg <= ST_S_CHK;
                end
                ST_S_CHK: begin
                    if (untried) begin
                        mask_reg[arm_idx] <= 1'b1;
                    end
                    n_reg <= n_new;
                    if (last_arm) begin
                        if (n_new != '0) begin
                            ucb_reg   <= 1'b0;
                            state_reg <= ST_MOD;
                        end else begin
                            m_reg     <= total_count_reg;
                            lk_reg    <= 5'd31;
                            state_reg <= ST_LOG_NORM;
                        end
                    end else begin
                        arm_reg   <= arm_reg + UW'(1);
                        state_reg <= ST_S_RD;
                    end
                end
                ST_LOG_NORM: begin
                    if (m_reg == '0) begin
                        lk_reg    <= '0;
                        frac_reg  <= '0;
                        state_reg <= ST_LN;
                    end else if (m_reg[31]) begin
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_LOG_SQ;
                    end else begin
                        m_reg  <= {m_reg[30:0], 1'b0};
                        lk_reg <= lk_reg - 5'd1;
                    end
                end
                ST_LOG_SQ: begin
                    // The squared mantissa crossing two yields the next fraction bit.
                    frac_reg <= {frac_reg[14:0], sq_t[32]};
                    m_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                    it_reg   <= it_reg + 5'd1;
                    if (it_reg == 5'd15) begin
                        state_reg <= ST_LN;
                    end
                end
                ST_LN: begin
                    ln_reg    <= ln_prod[36:16];
                    arm_reg   <= '0;
                    mask_reg  <= '0;
                    n_reg     <= '0;
                    state_reg <= ST_A_RD;
                end
                ST_A_RD: begin
                    state_reg <= ST_A_CAP;
                end
                ST_A_CAP: begin
                    mean_reg  <= mem_rd_mean;
                    state_reg <= ST_A_DIV;
                end
                ST_A_DIV: begin
                    if (div_rsp.done) begin
                        sq_v_reg   <= {div_rsp.quot[21:0], 16'b0};
                        sq_res_reg <= '0;
                        sq_bit_reg <= SQ_BIT0;
                        it_reg     <= '0;
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_v_reg >= sq_sum) begin
                        sq_v_reg   <= sq_v_reg - sq_sum;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    it_reg     <= it_reg + 5'd1;
                    if (it_reg == 5'd18) begin
                        state_reg <= ST_TERM;
                    end
                end
                ST_TERM: begin
                    term_reg  <= term_prod[34:12];
                    state_reg <= ST_SCORE;
                end
                ST_SCORE: begin
                    if (arm_reg == '0 || score > best_reg) begin
                        best_reg <= score;
                        mask_reg <= {{(NUM_ARMS-1){1'b0}}, 1'b1} << arm_idx;
                        n_reg    <= UW'(1);
                    end else if (score == best_reg) begin
                        mask_reg[arm_idx] <= 1'b1;
                        n_reg             <= n_reg + UW'(1);
                    end
                    if (last_arm) begin
                        ucb_reg   <= 1'b1;
                        state_reg <= ST_MOD;
                    end else begin
                        arm_reg   <= arm_reg + UW'(1);
                        state_reg <= ST_A_RD;
                    end
                end
                ST_MOD: begin
                    state_reg <= ST_MOD_WAIT;
                end
                ST_MOD_WAIT: begin
                    if (div_rsp.done) begin
                        k_reg     <= div_rsp.rem[UW-1:0];
                        arm_reg   <= '0;
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    // Walk the candidate mask and stop at the k-th marked arm.
                    if (mask_reg[arm_idx]) begin
                        if (k_reg == '0) begin
                            chosen_reg <= arm_idx;
                            if (ucb_reg) begin
                                walk_reg <= walk_next;
                                step_reg <= step_next;
                            end
                            state_reg <= ST_OUT;
                        end else begin
                            k_reg <= k_reg - UW'(1);
                        end
                    end
                    arm_reg <= arm_reg + UW'(1);
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (single_reg) begin
                            m_tdata_reg <= '0;
                            m_tuser_reg <= 1'b0;
                        end else begin
                            m_tdata_reg <= {5'b0, step_reg, walk_reg, 3'(chosen_reg)};
                            m_tuser_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `ASSERT_CLKD(a_mean_in_range, aclk, aresetn, mem_we |-> (mem_wr_mean <= REWARD_ONE), "arm mean left the unit range")
    `ASSERT_CLKD(a_total_mono, aclk, aresetn, 1'b1 |=> (total_count_reg >= $past(total_count_reg)), "total count went down")

endmodule
